FILE: rtl/core/was_pkg.sv
// weekly alarm scheduler package: item structs, opcodes and minute arithmetic
// used by the top level; depends on nothing
`timescale 1ns / 1ps

package was_pkg;

	localparam int NUM_ALARMS = 5;
	localparam int ALARM_W    = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int MIN_W      = 14;
	localparam int DIFF_W     = 16;

	localparam logic [DIFF_W-1:0] MIN_PER_WEEK   = DIFF_W'(10080);
	localparam logic [DIFF_W-1:0] MIN_PER_2WEEKS = DIFF_W'(20160);

	// opcodes of the input item
	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_RECOMPUTE = 2'd1;
	localparam logic [1:0] OP_STOP      = 2'd2;

	// alarm register packing
	localparam int A_MIN_LO  = 0;
	localparam int A_HOUR_LO = 6;
	localparam int A_MASK_LO = 11;
	localparam int A_EN_BIT  = 18;

	typedef struct packed {
		logic [1:0] opcode;
		logic [4:0] current_hour;
		logic [5:0] current_minute;
		logic [5:0] current_second;
		logic [2:0] current_weekday;
	} in_item_t;

	typedef struct packed {
		logic       next_valid;
		logic [2:0] next_index;
		logic [2:0] next_weekday;
		logic       ringing;
		logic       start_tone;
		logic       stop_tone;
	} out_item_t;

	// minutes at the start of a weekday, weekday seven included
	function automatic logic [MIN_W-1:0] day_minutes(input logic [2:0] d);
		logic [MIN_W-1:0] r;
		begin
			case (d)
				3'd0:    r = MIN_W'(0);
				3'd1:    r = MIN_W'(1440);
				3'd2:    r = MIN_W'(2880);
				3'd3:    r = MIN_W'(4320);
				3'd4:    r = MIN_W'(5760);
				3'd5:    r = MIN_W'(7200);
				3'd6:    r = MIN_W'(8640);
				default: r = MIN_W'(10080);
			endcase
			return r;
		end
	endfunction

	// hour times sixty as two shifts
	function automatic logic [10:0] hour_minutes(input logic [4:0] h);
		return {h, 6'b0} - {4'b0, h, 2'b0};
	endfunction

endpackage

FILE: rtl/core/weekly_alarm_scheduler.sv
// weekly alarm scheduler top level: alarm registers, tick matcher and the
// sequenced scan over alarms and weekdays; depends on was_pkg
// a tick that neither loses its match nor needs a scan gives its item in the cycle
// after it is taken; a recompute, a stop or a tick that ends ringing runs the scan
// of 5 alarms x 7 weekdays through one shared distance unit, one candidate a cycle,
// through its two stages, then a drain state and a finish state that waits for the output.
// one item at a time: a new item is taken no earlier than the cycle in which
// the previous result item leaves; reset clears alarms, next alarm and ringing state
`timescale 1ns / 1ps

module weekly_alarm_scheduler
	import was_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ALARM_W-1:0]   cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [2:0] LAST_SLOT = 3'(NUM_ALARMS - 1);
	localparam logic [2:0] LAST_DAY  = 3'd6;

	logic [1:0]         state_q;
	logic [ALARM_W-1:0] alarm_q [NUM_ALARMS];
	logic               next_ok_q;
	logic [2:0]         next_slot_q;
	logic [2:0]         next_day_q;
	logic               ring_q;
	logic               out_valid_q;
	out_item_t          out_q;
	logic               stop_pend_q;
	logic [MIN_W-1:0]   now_q;

	// scan sequencer and pipeline
	logic [2:0]              slot_q;
	logic [2:0]              day_q;
	logic                    vld_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic                    cval_s1;
	logic [2:0]              slot_s1;
	logic [2:0]              day_s1;
	logic                    found_q;
	logic [MIN_W-1:0]        best_q;
	logic [2:0]              best_slot_q;
	logic [2:0]              best_day_q;

	logic               in_fire;
	logic               out_free;
	logic [2:0]         rd_addr;
	logic [ALARM_W-1:0] rd_alarm;
	logic [7:0]         rd_mask8;
	logic               match_c;
	logic               ring_new_c;
	logic               tick_rescan_c;
	logic               start_scan_c;
	logic [MIN_W-1:0]   now_c;
	logic [MIN_W-1:0]   alarm_min_c;
	logic signed [DIFF_W-1:0] diff_c;
	logic signed [DIFF_W-1:0] wrap1_c;
	logic signed [DIFF_W-1:0] wrap2_c;
	logic [MIN_W-1:0]   dist_c;
	logic               better_c;
	logic               fin_go;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign fin_go    = (state_q == ST_FIN) && out_free;

	// single read port of the alarm registers: next alarm when idle, scan slot otherwise
	assign rd_addr  = (state_q == ST_IDLE) ? next_slot_q : slot_q;
	assign rd_alarm = alarm_q[rd_addr];
	assign rd_mask8 = {1'b0, rd_alarm[A_MASK_LO +: 7]};

	// tick match against the next alarm; weekday seven hits the zero bit
	assign match_c = next_ok_q && rd_mask8[in_item.current_weekday]
		&& (rd_alarm[A_HOUR_LO +: 5] == in_item.current_hour)
		&& (rd_alarm[A_MIN_LO +: 6] == in_item.current_minute);
	assign ring_new_c    = ring_q || (match_c && (in_item.current_second == 6'd0));
	assign tick_rescan_c = ring_new_c && !match_c;

	always_comb begin
		case (in_item.opcode)
			OP_TICK:      start_scan_c = tick_rescan_c;
			OP_RECOMPUTE: start_scan_c = 1'b1;
			OP_STOP:      start_scan_c = 1'b1;
			default:      start_scan_c = 1'b0;
		endcase
	end

	// now plus one minute
	assign now_c = day_minutes(in_item.current_weekday)
		+ MIN_W'(hour_minutes(in_item.current_hour))
		+ MIN_W'(in_item.current_minute) + MIN_W'(1);

	// stage 1: raw distance of the current candidate
	assign alarm_min_c = day_minutes(day_q)
		+ MIN_W'(hour_minutes(rd_alarm[A_HOUR_LO +: 5]))
		+ MIN_W'(rd_alarm[A_MIN_LO +: 6]);
	assign diff_c = $signed({2'b00, alarm_min_c}) - $signed({2'b00, now_q});

	// stage 2: wrap by up to two weeks, then compare with the best so far
	assign wrap1_c = diff_s1 + $signed(MIN_PER_WEEK);
	assign wrap2_c = diff_s1 + $signed(MIN_PER_2WEEKS);
	always_comb begin
		if (!diff_s1[DIFF_W-1]) begin
			dist_c = diff_s1[MIN_W-1:0];
		end else if (!wrap1_c[DIFF_W-1]) begin
			dist_c = wrap1_c[MIN_W-1:0];
		end else begin
			dist_c = wrap2_c[MIN_W-1:0];
		end
	end
	assign better_c = vld_s1 && cval_s1 && (!found_q || (dist_c < best_q));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_ok_q   <= 1'b0;
			next_slot_q <= 3'd0;
			next_day_q  <= 3'd0;
			ring_q      <= 1'b0;
			out_valid_q <= 1'b0;
			slot_q      <= 3'd0;
			day_q       <= 3'd0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			for (int i = 0; i < NUM_ALARMS; i++) begin
				alarm_q[i] <= '0;
			end
		end else begin
			// configuration writes, indexes past the last alarm ignored
			if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_ALARMS))) begin
				alarm_q[cfg_index] <= cfg_data;
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			vld_s1 <= (state_q == ST_SCAN);
			if (better_c) begin
				found_q <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (start_scan_c) begin
							state_q <= ST_SCAN;
							slot_q  <= 3'd0;
							day_q   <= 3'd0;
							found_q <= 1'b0;
							if (in_item.opcode != OP_RECOMPUTE) begin
								ring_q <= 1'b0;
							end
						end else begin
							out_valid_q <= 1'b1;
							if (in_item.opcode == OP_TICK) begin
								ring_q <= ring_new_c;
							end
						end
					end
				end
				ST_SCAN: begin
					if (day_q == LAST_DAY) begin
						day_q <= 3'd0;
						if (slot_q == LAST_SLOT) begin
							state_q <= ST_DRAIN;
						end else begin
							slot_q <= slot_q + 3'd1;
						end
					end else begin
						day_q <= day_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						next_ok_q   <= found_q;
						next_slot_q <= found_q ? best_slot_q : 3'd0;
						next_day_q  <= found_q ? best_day_q : 3'd0;
						slot_q      <= 3'd0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		// scan stage 1 capture
		diff_s1 <= diff_c;
		cval_s1 <= rd_alarm[A_EN_BIT] && rd_mask8[day_q];
		slot_s1 <= slot_q;
		day_s1  <= day_q;

		// best candidate so far
		if (better_c) begin
			best_q      <= dist_c;
			best_slot_q <= slot_s1;
			best_day_q  <= day_s1;
		end

		if (in_fire) begin
			now_q       <= now_c;
			stop_pend_q <= (in_item.opcode != OP_RECOMPUTE) && ring_q;
			if (!start_scan_c) begin
				out_q.next_valid   <= next_ok_q;
				out_q.next_index   <= next_slot_q;
				out_q.next_weekday <= next_day_q;
				out_q.stop_tone    <= 1'b0;
				if (in_item.opcode == OP_TICK) begin
					out_q.ringing    <= ring_new_c;
					out_q.start_tone <= ring_new_c && !ring_q;
				end else begin
					out_q.ringing    <= ring_q;
					out_q.start_tone <= 1'b0;
				end
			end
		end

		// result item of a scan
		if (fin_go) begin
			out_q.next_valid   <= found_q;
			out_q.next_index   <= found_q ? best_slot_q : 3'd0;
			out_q.next_weekday <= found_q ? best_day_q : 3'd0;
			out_q.ringing      <= ring_q;
			out_q.start_tone   <= 1'b0;
			out_q.stop_tone    <= stop_pend_q;
		end
	end

endmodule

FILE: verif/weekly_alarm_scheduler_test.sv
// testbench for the weekly alarm scheduler: drives alarm writes and time items,
// predicts every result item in a scoreboard class and checks it field by field
// depends on was_pkg and the weekly_alarm_scheduler top level
`timescale 1ns / 1ps

module weekly_alarm_scheduler_test
	import was_pkg::*;
();

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DAY_MIN     = 1440;
	localparam int HOUR_MIN    = 60;
	localparam int WEEK_MIN    = 10080;
	localparam int MAX_SHOWN   = 10;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	// scoreboard: alarm copy, next alarm and ringing state, pending result items
	class alarm_board;
		logic [ALARM_W-1:0] alarm [NUM_ALARMS];
		logic               have_next;
		logic [2:0]         next_slot;
		logic [2:0]         next_day;
		logic               ringing;
		out_item_t          due [$];
		int                 errors;

		function new();
			foreach (alarm[i]) alarm[i] = '0;
			have_next = 1'b0;
			next_slot = '0;
			next_day  = '0;
			ringing   = 1'b0;
			errors    = 0;
		endfunction

		function void write_alarm(input logic [CFG_IDX_W-1:0] idx,
				input logic [ALARM_W-1:0] v);
			if (idx < NUM_ALARMS) alarm[idx] = v;
		endfunction

		// nearest enabled alarm instant from one minute past the given time
		function void find_next(input logic [4:0] hr, input logic [5:0] mn,
				input logic [2:0] wd, output logic hit, output logic [2:0] who,
				output logic [2:0] wday);
			int now_min;
			int span;
			int best;
			hit  = 1'b0;
			who  = '0;
			wday = '0;
			best = 0;
			now_min = int'(wd) * DAY_MIN + int'(hr) * HOUR_MIN + int'(mn) + 1;
			for (int i = 0; i < NUM_ALARMS; i++) begin
				if (!alarm[i][A_EN_BIT]) continue;
				for (int d = 0; d < 7; d++) begin
					if (!alarm[i][A_MASK_LO + d]) continue;
					span = d * DAY_MIN + int'(alarm[i][A_HOUR_LO +: 5]) * HOUR_MIN
						+ int'(alarm[i][A_MIN_LO +: 6]) - now_min;
					while (span < 0) span += WEEK_MIN;
					if (!hit || span < best) begin
						hit  = 1'b1;
						best = span;
						who  = 3'(i);
						wday = 3'(d);
					end
				end
			end
		endfunction

		function void rescan(input in_item_t it);
			find_next(it.current_hour, it.current_minute, it.current_weekday,
				have_next, next_slot, next_day);
		endfunction

		// accepted input item: advance the state and queue the expected result
		function void note(input in_item_t it);
			out_item_t          want;
			logic               was_ringing;
			logic               hit;
			logic [ALARM_W-1:0] a;
			want = '0;
			case (it.opcode)
				OP_TICK: begin
					was_ringing = ringing;
					hit = 1'b0;
					if (have_next && next_slot < NUM_ALARMS) begin
						a = alarm[next_slot];
						hit = (it.current_weekday != 3'd7)
							&& a[A_MASK_LO + int'(it.current_weekday)]
							&& (a[A_HOUR_LO +: 5] == it.current_hour)
							&& (a[A_MIN_LO +: 6] == it.current_minute);
					end
					if (hit && it.current_second == '0) ringing = 1'b1;
					if (ringing) begin
						if (hit) begin
							want.start_tone = !was_ringing;
						end else begin
							rescan(it);
							ringing = 1'b0;
							want.stop_tone = 1'b1;
						end
					end
				end
				OP_RECOMPUTE: begin
					rescan(it);
				end
				OP_STOP: begin
					rescan(it);
					want.stop_tone = ringing;
					ringing = 1'b0;
				end
				default: begin
				end
			endcase
			want.next_valid   = have_next;
			want.next_index   = next_slot;
			want.next_weekday = next_day;
			want.ringing      = ringing;
			due.push_back(want);
		endfunction

		// accepted result item against the oldest expectation
		function void check(input out_item_t got);
			out_item_t want;
			logic      bad;
			if (due.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("result item %h arrived with nothing pending", got);
				return;
			end
			want = due.pop_front();
			bad = (got.next_valid !== want.next_valid)
				|| (got.next_index !== want.next_index)
				|| (got.next_weekday !== want.next_weekday)
				|| (got.ringing !== want.ringing)
				|| (got.start_tone !== want.start_tone)
				|| (got.stop_tone !== want.stop_tone);
			if (bad) begin
				errors++;
				if (errors <= MAX_SHOWN) begin
					$display("mismatch: expected valid %b index %0d day %0d ring %b start %b stop %b",
						want.next_valid, want.next_index, want.next_weekday,
						want.ringing, want.start_tone, want.stop_tone);
					$display("          got      valid %b index %0d day %0d ring %b start %b stop %b",
						got.next_valid, got.next_index, got.next_weekday,
						got.ringing, got.start_tone, got.stop_tone);
				end
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ALARM_W-1:0]   cfg_data  = '0;

	alarm_board         board;
	logic [ALARM_W-1:0] plan [NUM_ALARMS];
	bit                 calm     = 1'b0;
	bit                 hold_req = 1'b0;
	int                 sent     = 0;
	int                 idle_run = 0;

	weekly_alarm_scheduler i_dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor: alarm writes, input items and result items
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.write_alarm(cfg_index, cfg_data);
			if (in_valid && in_ready) board.note(in_item);
			if (out_valid && out_ready) board.check(out_item);
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_run <= 0;
			else
				idle_run <= idle_run + 1;
			if (idle_run >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold on request
	initial begin : result_side
		int  len;
		int  roll;
		bit  level;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				level = 1'b0;
				len = HOLD_CYCLES;
			end else if (calm) begin
				level = 1'b1;
				len = 1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 60) begin
					level = 1'b1;
					len = $urandom_range(1, 8);
				end else if (roll < 92) begin
					level = 1'b0;
					len = $urandom_range(1, 4);
				end else begin
					level = 1'b0;
					len = $urandom_range(15, 60);
				end
			end
			out_ready <= level;
			repeat (len) @(posedge clk);
		end
	end

	// offer one time item and hold it until accepted, then maybe idle
	task automatic offer(input logic [1:0] op, input logic [4:0] hr, input logic [5:0] mn,
			input logic [5:0] sc, input logic [2:0] wd);
		in_item_t it;
		int       gap;
		int       roll;
		it.opcode          = op;
		it.current_hour    = hr;
		it.current_minute  = mn;
		it.current_second  = sc;
		it.current_weekday = wd;
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		gap = 0;
		if (!calm) begin
			roll = $urandom_range(0, 99);
			if (roll >= 92) gap = $urandom_range(10, 40);
			else if (roll >= 55) gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait until every pending result item is back
	task automatic settle(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ALARM_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// quiet block, then load the planned alarms and maybe the unused indexes
	task automatic configure(input bit stray);
		settle(45);
		for (int i = 0; i < NUM_ALARMS; i++) cfg_write(CFG_IDX_W'(i), plan[i]);
		if (stray)
			for (int i = NUM_ALARMS; i < (1 << CFG_IDX_W); i++)
				cfg_write(CFG_IDX_W'(i), ALARM_W'($urandom));
	endtask

	function automatic logic [ALARM_W-1:0] pick_alarm();
		return {1'($urandom_range(0, 5) != 0), 7'($urandom_range(1, 127)),
			5'($urandom_range(0, 23)), 6'($urandom_range(0, 59))};
	endfunction

	// random traffic: mostly recompute then ring sequences, the rest noise
	task automatic run_random(input int count);
		int                 goal;
		int                 mid;
		int                 roll;
		int                 k;
		bit                 paused;
		logic [4:0]         hr;
		logic [5:0]         mn;
		logic [2:0]         wd;
		logic [4:0]         th;
		logic [5:0]         tm;
		logic               hit;
		logic [2:0]         who;
		logic [2:0]         wday;
		logic [ALARM_W-1:0] a;
		goal = sent + count;
		mid = sent + count / 2;
		paused = 1'b0;
		while (sent < goal) begin
			if (!paused && sent >= mid) begin
				settle(0);
				paused = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				hr = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
				mn = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
				wd = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
				offer(($urandom_range(0, 3) == 0) ? OP_STOP : OP_RECOMPUTE,
					hr, mn, 6'($urandom), wd);
				board.find_next(hr, mn, wd, hit, who, wday);
				if (hit) begin
					a = board.alarm[who];
					th = a[A_HOUR_LO +: 5];
					tm = a[A_MIN_LO +: 6];
					// quiet seconds before the alarm minute
					repeat ($urandom_range(0, 2))
						offer(OP_TICK, hr, mn, 6'($urandom_range(1, 59)), wd);
					// alarm minute, mostly at second zero
					offer(OP_TICK, th, tm,
						($urandom_range(0, 4) == 0) ? 6'($urandom_range(1, 59)) : 6'd0, wday);
					k = $urandom_range(0, 4);
					for (int j = 1; j <= k; j++) offer(OP_TICK, th, tm, 6'(j), wday);
					// way out of the ringing minute
					roll = $urandom_range(0, 99);
					if (roll < 40) begin
						offer(OP_TICK, th, tm + 6'd1, 6'd0, wday);
					end else if (roll < 65) begin
						offer(OP_STOP, th, tm, 6'(k + 1), wday);
					end else if (roll < 80) begin
						offer(OP_RECOMPUTE, th, tm, 6'(k + 1), wday);
						offer(OP_TICK, th, tm, 6'(k + 2), wday);
						offer(OP_TICK, th, tm + 6'd1, 6'd0, wday);
					end else if (roll < 90) begin
						offer(OP_UNUSED, th, tm, 6'($urandom), wday);
						offer(OP_STOP, th, tm, 6'(k + 2), wday);
					end
				end
			end else if (roll < 85) begin
				offer(2'($urandom), 5'($urandom), 6'($urandom), 6'($urandom), 3'($urandom));
			end else begin
				offer(2'($urandom_range(0, 2)), 5'($urandom_range(0, 23)),
					6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
					3'($urandom_range(0, 6)));
			end
		end
	endtask

	task automatic phase(input int count, input bit stray, input bit squeeze);
		configure(stray);
		if (squeeze) hold_req = 1'b1;
		run_random(count);
	endtask

	// main sequence
	initial begin : main_flow
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no alarm configured yet
		offer(OP_TICK, 5'd0, 6'd0, 6'd0, 3'd0);
		offer(OP_UNUSED, 5'h1f, 6'h3f, 6'h3f, 3'd7);
		offer(OP_RECOMPUTE, 5'd0, 6'd0, 6'd0, 3'd0);
		offer(OP_STOP, 5'd12, 6'd0, 6'd30, 3'd3);

		// daily 07:30 twice (tie), empty mask, disabled alarm, sunday-like 23:59
		plan[0] = {1'b1, 7'h7f, 5'd7, 6'd30};
		plan[1] = {1'b1, 7'h00, 5'd12, 6'd0};
		plan[2] = {1'b1, 7'h7f, 5'd7, 6'd30};
		plan[3] = {1'b0, 7'h7f, 5'd7, 6'd0};
		plan[4] = {1'b1, 7'h40, 5'd23, 6'd59};
		configure(1'b1);
		offer(OP_RECOMPUTE, 5'h1f, 6'h3f, 6'd0, 3'd7);
		offer(OP_RECOMPUTE, 5'd7, 6'd29, 6'd0, 3'd0);
		offer(OP_TICK, 5'd7, 6'd30, 6'd5, 3'd0);
		offer(OP_TICK, 5'd7, 6'd30, 6'd0, 3'd0);
		offer(OP_TICK, 5'd7, 6'd30, 6'd1, 3'd0);
		offer(OP_RECOMPUTE, 5'd7, 6'd30, 6'd1, 3'd0);
		offer(OP_TICK, 5'd7, 6'd30, 6'd2, 3'd0);
		offer(OP_UNUSED, 5'd7, 6'd30, 6'd3, 3'd0);
		offer(OP_TICK, 5'd7, 6'd31, 6'd0, 3'd0);
		offer(OP_RECOMPUTE, 5'd7, 6'd29, 6'd0, 3'd0);
		offer(OP_TICK, 5'd7, 6'd30, 6'd0, 3'd0);
		offer(OP_STOP, 5'd7, 6'd30, 6'd4, 3'd0);
		offer(OP_STOP, 5'd7, 6'd30, 6'd5, 3'd0);
		offer(OP_TICK, 5'd7, 6'd30, 6'd0, 3'd7);
		offer(OP_RECOMPUTE, 5'd23, 6'd59, 6'd0, 3'd6);
		offer(OP_RECOMPUTE, 5'd23, 6'd58, 6'd0, 3'd6);
		offer(OP_TICK, 5'd23, 6'd59, 6'd0, 3'd6);
		offer(OP_TICK, 5'd0, 6'd0, 6'd0, 3'd0);
		offer(OP_TICK, 5'h1f, 6'h3f, 6'h3f, 3'd7);

		// in-range random alarms
		foreach (plan[i]) plan[i] = pick_alarm();
		phase(300, 1'b0, 1'b0);

		// every field at its top, back to back with no idling
		foreach (plan[i]) plan[i] = '1;
		calm = 1'b1;
		phase(150, 1'b0, 1'b0);
		calm = 1'b0;

		// raw random register values
		foreach (plan[i]) plan[i] = ALARM_W'($urandom);
		phase(300, 1'b1, 1'b0);

		// everything cleared: never a next alarm
		foreach (plan[i]) plan[i] = '0;
		phase(80, 1'b0, 1'b0);

		// single days, a tie between slots one and three, an empty mask
		plan[0] = {1'b1, 7'h01, 5'd6, 6'd0};
		plan[1] = {1'b1, 7'h7f, 5'd8, 6'd15};
		plan[2] = {1'b1, 7'h00, 5'd5, 6'd0};
		plan[3] = {1'b1, 7'h7f, 5'd8, 6'd15};
		plan[4] = {1'b1, 7'h40, 5'd23, 6'd59};
		phase(250, 1'b1, 1'b0);

		// in-range random alarms with a long result-side hold up front
		foreach (plan[i]) plan[i] = pick_alarm();
		phase(250, 1'b0, 1'b1);

		settle(60);
		if (board.errors == 0 && board.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
